### rtl/tst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat package
// Shared types, register map and reset values for the hysteresis thermostat
// with its latched safety trip.
// ----------------------------------------------------------------------------
package tst_pkg;

    // Configuration port geometry: five 32-bit registers at byte address 4*i.
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REGIDX_W = 3;

    // Register indexes.
    localparam logic [REGIDX_W-1:0] REG_TARGET_TEMP  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_MAX_TEMP     = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_ALLOWANCE    = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_NEEDED_RISE  = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_RISE_WAIT_MS = 3'd4;

    // Reset values (temperatures in 1/16 degree C).
    localparam logic signed [11:0] TARGET_TEMP_RST  = 12'sd384;    // 24.0 C
    localparam logic signed [11:0] MAX_TEMP_RST     = 12'sd448;    // 28.0 C
    localparam logic [7:0]         ALLOWANCE_RST    = 8'd4;        // 0.25 C
    localparam logic [7:0]         NEEDED_RISE_RST  = 8'd4;        // 0.25 C
    localparam logic [23:0]        RISE_WAIT_MS_RST = 24'd180000;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_LOST   = 2'd2,
        KIND_STOP   = 2'd3
    } kind_t;

    // Controller modes.
    typedef enum logic [1:0] {
        MODE_COOL = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_TRIP = 2'd2
    } mode_t;

    // Trip reasons.
    typedef enum logic [2:0] {
        WHY_NONE    = 3'd0,
        WHY_SENSOR  = 3'd1,
        WHY_OVERMAX = 3'd2,
        WHY_NORISE  = 3'd3,
        WHY_STOP    = 3'd4
    } reason_t;

    // Configuration register set as seen by the controller.
    typedef struct packed {
        logic signed [11:0] target_temp;
        logic signed [11:0] max_temp;
        logic [7:0]         allowance;
        logic [7:0]         needed_rise;
        logic [23:0]        rise_wait_ms;
    } cfg_t;

    // Input beat.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [11:0] temperature;
    } item_t;

    // Result beat.
    typedef struct packed {
        logic       heater_on;
        logic [1:0] mode;
        logic [2:0] trip_reason;
    } result_t;

endpackage

### rtl/tst_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat configuration registers
// APB-style register file holding setpoint, trip level, hysteresis,
// needed rise and watchdog wait time.
// ----------------------------------------------------------------------------
module tst_cfg
    import tst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t                cfg_reg;
    logic                wr_en;
    logic [REGIDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes; indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp  <= TARGET_TEMP_RST;
            cfg_reg.max_temp     <= MAX_TEMP_RST;
            cfg_reg.allowance    <= ALLOWANCE_RST;
            cfg_reg.needed_rise  <= NEEDED_RISE_RST;
            cfg_reg.rise_wait_ms <= RISE_WAIT_MS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET_TEMP:  cfg_reg.target_temp  <= $signed(pwdata[11:0]);
                REG_MAX_TEMP:     cfg_reg.max_temp     <= $signed(pwdata[11:0]);
                REG_ALLOWANCE:    cfg_reg.allowance    <= pwdata[7:0];
                REG_NEEDED_RISE:  cfg_reg.needed_rise  <= pwdata[7:0];
                REG_RISE_WAIT_MS: cfg_reg.rise_wait_ms <= pwdata[23:0];
                default:          ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            REG_TARGET_TEMP:  prdata = {20'd0, cfg_reg.target_temp};
            REG_MAX_TEMP:     prdata = {20'd0, cfg_reg.max_temp};
            REG_ALLOWANCE:    prdata = {24'd0, cfg_reg.allowance};
            REG_NEEDED_RISE:  prdata = {24'd0, cfg_reg.needed_rise};
            REG_RISE_WAIT_MS: prdata = {8'd0, cfg_reg.rise_wait_ms};
            default:          prdata = '0;
        endcase
    end

endmodule

### rtl/tst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat controller
// Input register, single-pass mode and watchdog update, and result register.
// ----------------------------------------------------------------------------
module tst_ctrl
    import tst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Input stage.
    logic  item_valid_reg, item_valid_next;
    item_t item_reg;
    logic  advance;

    // Controller state.
    mode_t              mode_reg, mode_next;
    logic               heater_reg, heater_next;
    reason_t            reason_reg, reason_next;
    logic               armed_reg, armed_next;
    logic signed [11:0] start_temp_reg, start_temp_next;
    logic [23:0]        elapsed_reg, elapsed_next;

    // Result stage.
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // Working values for a sample.
    logic signed [11:0] t;
    logic signed [12:0] t_x;
    logic signed [12:0] upper;
    logic signed [12:0] lower;
    logic signed [11:0] start_eff;
    logic [23:0]        elapsed_eff;
    logic signed [12:0] rise;
    logic               wait_over;

    // The input stage moves on when the result register is free or being taken.
    assign advance      = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign item_valid_next   = item_ready ? item_valid : item_valid_reg;
    assign result_valid_next = advance || (result_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // Band edges, rise since arming and watchdog expiry.
    always_comb
    begin
        t           = item_reg.temperature;
        t_x         = {t[11], t};
        upper       = {cfg.target_temp[11], cfg.target_temp} + $signed({5'd0, cfg.allowance});
        lower       = {cfg.target_temp[11], cfg.target_temp} - $signed({5'd0, cfg.allowance});
        start_eff   = armed_reg ? start_temp_reg : t;
        elapsed_eff = armed_reg ? elapsed_reg : 24'd0;
        rise        = t_x - {start_eff[11], start_eff};
        wait_over   = (elapsed_eff >= cfg.rise_wait_ms);
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_COOL;
            heater_reg  <= 1'b0;
            reason_reg  <= WHY_NONE;
            armed_reg   <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            heater_reg  <= heater_next;
            reason_reg  <= reason_next;
            armed_reg   <= armed_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_temp_reg <= start_temp_next;
    end

    // Next state for one beat. Once tripped, every beat is ignored.
    always_comb
    begin
        mode_next       = mode_reg;
        heater_next     = heater_reg;
        reason_next     = reason_reg;
        armed_next      = armed_reg;
        start_temp_next = start_temp_reg;
        elapsed_next    = elapsed_reg;

        if (advance && mode_reg != MODE_TRIP)
        begin
            case (kind_t'(item_reg.kind))
                KIND_TICK:
                begin
                    if (armed_reg && elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + 24'd1;
                    end
                end
                KIND_SAMPLE:
                begin
                    if (t >= cfg.max_temp)
                    begin
                        mode_next   = MODE_TRIP;
                        heater_next = 1'b0;
                        reason_next = WHY_OVERMAX;
                        armed_next  = 1'b0;
                    end
                    else if (mode_reg == MODE_HEAT)
                    begin
                        // The first sample in heating arms the watchdog.
                        armed_next = 1'b1;
                        if (!armed_reg)
                        begin
                            start_temp_next = t;
                            elapsed_next    = '0;
                        end
                        if (wait_over && rise < $signed({5'd0, cfg.needed_rise}))
                        begin
                            mode_next   = MODE_TRIP;
                            heater_next = 1'b0;
                            reason_next = WHY_NORISE;
                            armed_next  = 1'b0;
                        end
                        else if (t_x >= upper)
                        begin
                            mode_next   = MODE_COOL;
                            heater_next = 1'b0;
                            armed_next  = 1'b0;
                        end
                    end
                    else if (t_x <= lower)
                    begin
                        mode_next   = MODE_HEAT;
                        heater_next = 1'b1;
                        armed_next  = 1'b0;
                    end
                end
                KIND_LOST:
                begin
                    mode_next   = MODE_TRIP;
                    heater_next = 1'b0;
                    reason_next = WHY_SENSOR;
                    armed_next  = 1'b0;
                end
                KIND_STOP:
                begin
                    mode_next   = MODE_TRIP;
                    heater_next = 1'b0;
                    reason_next = WHY_STOP;
                    armed_next  = 1'b0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    // Result register: each beat reports the state it leaves behind.
    always_comb
    begin
        result_next             = result_reg;
        if (advance)
        begin
            result_next.heater_on   = heater_next;
            result_next.mode        = mode_next;
            result_next.trip_reason = reason_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

### rtl/thermostat_with_safety_trip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat with safety trip
// Hysteresis heater control with over-temperature, no-rise watchdog,
// sensor-lost and external-stop trips.
// ----------------------------------------------------------------------------
// Each input beat (a millisecond tick, a temperature sample, a sensor-lost
// or an external-stop event) yields exactly one result beat carrying the
// heater drive, the mode and the latched trip reason after that beat. A beat
// is captured in an input register when accepted, and its result is loaded
// into the result register once that register is free or being taken; a
// stalled result holds the beat in the input register. A new beat is taken
// every cycle while results are drained; the single-pass mode and watchdog
// update sets that rate. A trip holds the heater off until reset.
// Configuration registers sit on the APB port at byte address 4*i and are
// meant to be written while no beat is in flight.
module thermostat_with_safety_trip
    import tst_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result
);

    cfg_t cfg;

    // Configuration registers.
    tst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Controller datapath.
    tst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### rtl/tst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermostat port checker
// Watches the result channel for consistency of mode, heater and trip reason.
// ----------------------------------------------------------------------------
module tst_checker
    import tst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result
);

    logic       seen_trip_reg;
    logic [2:0] trip_reason_reg;

    // Remember the first trip reported on the result channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_trip_reg   <= 1'b0;
            trip_reason_reg <= WHY_NONE;
        end
        else if (result_valid && result_ready && !seen_trip_reg &&
                 result.mode == MODE_TRIP)
        begin
            seen_trip_reg   <= 1'b1;
            trip_reason_reg <= result.trip_reason;
        end
    end

    // A stalled result beat holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // The heater runs exactly in heating mode.
    a_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.heater_on == (result.mode == MODE_HEAT)))
        else $error("heater drive disagrees with mode");

    // A reason is reported exactly while tripped.
    a_reason_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.trip_reason != WHY_NONE) == (result.mode == MODE_TRIP)))
        else $error("trip reason disagrees with mode");

    // A trip stays latched with its first reason.
    a_trip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seen_trip_reg |->
            result.mode == MODE_TRIP && result.trip_reason == trip_reason_reg)
        else $error("trip released or reason changed");

endmodule

bind thermostat_with_safety_trip tst_checker u_tst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
